// ===== rtl/pmu_pkg.sv =====
// ----------------------------------------------------------------------------
// pmu_pkg
// Shared types, register indexes and helpers of the particle motion update.
// ----------------------------------------------------------------------------
package pmu_pkg;

	localparam int AXES = 3;

	localparam logic [2:0] REG_DAMP_X    = 3'd0;
	localparam logic [2:0] REG_DAMP_Y    = 3'd1;
	localparam logic [2:0] REG_DAMP_Z    = 3'd2;
	localparam logic [2:0] REG_MIN_SPEED = 3'd3;
	localparam logic [2:0] REG_MAX_SPEED = 3'd4;
	localparam logic [2:0] REG_TIME_STEP = 3'd5;

	localparam logic [15:0] DAMP_ONE      = 16'd16384;
	localparam logic [31:0] MAX_UNLIMITED = 32'hFFFF_FFFF;
	localparam logic [63:0] MAX_SQ_RESET  = 64'hFFFF_FFFE_0000_0001;

	typedef logic signed [31:0] q16_t;

	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,
		ACT_CAP   = 2'd1,
		ACT_RAISE = 2'd2
	} act_t;

	typedef struct packed {
		logic [AXES-1:0][31:0] pos;
		logic [AXES-1:0][31:0] vel;
		act_t                  act;
		logic [31:0]           target;
	} side_t;

	typedef struct packed {
		logic [AXES-1:0][15:0] damp;
		logic [31:0]           max_speed;
		logic [19:0]           time_step;
		logic [63:0]           min_sq;
		logic [63:0]           max_sq;
	} cfg_t;

	function automatic q16_t sat32(logic signed [63:0] x);
		q16_t r;
		if (x > 64'sd2147483647) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -64'sd2147483648) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic [31:0] abs32(logic [31:0] v);
		logic [31:0] r;
		r = v[31] ? (~v + 32'd1) : v;
		return r;
	endfunction

endpackage

// ===== rtl/pmu_if.sv =====
// ----------------------------------------------------------------------------
// pmu_if
// Valid/ready channels of the particle motion update: particle in, result
// out, register write.
// ----------------------------------------------------------------------------
interface pmu_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [31:0] vel_x;
	logic [31:0] vel_y;
	logic [31:0] vel_z;
	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface pmu_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] new_pos_x;
	logic [31:0] new_pos_y;
	logic [31:0] new_pos_z;
	logic [31:0] new_vel_x;
	logic [31:0] new_vel_y;
	logic [31:0] new_vel_z;
	logic [1:0]  speed_action;
	modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
		new_vel_z, speed_action, input ready);
	modport sink (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
		new_vel_z, speed_action, output ready);
endinterface

interface pmu_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/particle_motion_update.sv =====
// ----------------------------------------------------------------------------
// particle_motion_update
// Pipeline sections in order: front, square root, rescale, position step.
// Throughput one particle word per cycle; every stage is a register with a
// valid bit, and the whole pipeline holds while the result word is stalled.
// Reset (arst_n low) clears all valid bits and loads the register defaults:
// damping 1.0, no minimum, no cap, zero time step.
// ----------------------------------------------------------------------------
module particle_motion_update import pmu_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	pmu_in_if.sink   particle,
	pmu_out_if.source result,
	pmu_cfg_if.sink  cfg
);

	logic [AXES-1:0][15:0] damp_q;
	logic [31:0]           min_speed_q, max_speed_q;
	logic [19:0]           time_step_q;
	logic [63:0]           min_sq_q, max_sq_q;
	cfg_t                  cfg_w;
	logic                  adv;

	logic        f_valid, q_valid, d_valid, r_valid;
	side_t       f_side, q_side, d_side, r_side;
	logic [63:0] f_vsq;
	logic [31:0] q_mag;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damp_q      <= {AXES{DAMP_ONE}};
			min_speed_q <= 32'd0;
			max_speed_q <= MAX_UNLIMITED;
			time_step_q <= 20'd0;
			min_sq_q    <= 64'd0;
			max_sq_q    <= MAX_SQ_RESET;
		end else begin
			min_sq_q <= min_speed_q * min_speed_q;
			max_sq_q <= max_speed_q * max_speed_q;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_DAMP_X:    damp_q[0]   <= cfg.data[15:0];
					REG_DAMP_Y:    damp_q[1]   <= cfg.data[15:0];
					REG_DAMP_Z:    damp_q[2]   <= cfg.data[15:0];
					REG_MIN_SPEED: min_speed_q <= cfg.data;
					REG_MAX_SPEED: max_speed_q <= cfg.data;
					REG_TIME_STEP: time_step_q <= cfg.data[19:0];
					default: ;
				endcase
			end
		end
	end

	assign cfg_w.damp      = damp_q;
	assign cfg_w.max_speed = max_speed_q;
	assign cfg_w.time_step = time_step_q;
	assign cfg_w.min_sq    = min_sq_q;
	assign cfg_w.max_sq    = max_sq_q;

	assign adv            = !r_valid || result.ready;
	assign particle.ready = adv;

	pmu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (particle.valid),
		.in_pos    ({particle.pos_z, particle.pos_y, particle.pos_x}),
		.in_vel    ({particle.vel_z, particle.vel_y, particle.vel_x}),
		.cfg       (cfg_w),
		.min_speed (min_speed_q),
		.out_valid (f_valid),
		.out_side  (f_side),
		.out_vsq   (f_vsq)
	);

	pmu_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (f_valid),
		.in_side   (f_side),
		.in_vsq    (f_vsq),
		.out_valid (q_valid),
		.out_side  (q_side),
		.out_mag   (q_mag)
	);

	pmu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (q_valid),
		.in_side   (q_side),
		.in_mag    (q_mag),
		.out_valid (d_valid),
		.out_side  (d_side)
	);

	pmu_rear u_rear (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (d_valid),
		.in_side   (d_side),
		.time_step (cfg_w.time_step),
		.out_valid (r_valid),
		.out_side  (r_side)
	);

	assign result.valid        = r_valid;
	assign result.new_pos_x    = r_side.pos[0];
	assign result.new_pos_y    = r_side.pos[1];
	assign result.new_pos_z    = r_side.pos[2];
	assign result.new_vel_x    = r_side.vel[0];
	assign result.new_vel_y    = r_side.vel[1];
	assign result.new_vel_z    = r_side.vel[2];
	assign result.speed_action = r_side.act;

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !particle.ready)
		else $error("input taken while result word stalled");

	a_cap_needs_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.speed_action == ACT_CAP |-> max_speed_q != MAX_UNLIMITED)
		else $error("capped with unlimited maximum speed");

	a_raise_needs_min: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.speed_action == ACT_RAISE |-> min_speed_q != 32'd0)
		else $error("raised with zero minimum speed");

endmodule

// ===== rtl/pmu_front.sv =====
// ----------------------------------------------------------------------------
// pmu_front
// Damping, squared speed and the cap/raise decision, five stages.
// ----------------------------------------------------------------------------
module pmu_front import pmu_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_valid,
	input  logic [AXES-1:0][31:0] in_pos,
	input  logic [AXES-1:0][31:0] in_vel,
	input  cfg_t                  cfg,
	input  logic [31:0]           min_speed,
	output logic                  out_valid,
	output side_t                 out_side,
	output logic [63:0]           out_vsq
);

	logic                  v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [48:0]    prod_s1 [AXES];
	logic [AXES-1:0][31:0] pos_s1, pos_s2, pos_s3, pos_s4, pos_s5;
	logic [AXES-1:0][31:0] vel_s2, vel_s3, vel_s4, vel_s5;
	logic [63:0]           sq_s3 [AXES];
	logic [63:0]           vsq_s4, vsq_s5;
	act_t                  act_s5;
	logic [31:0]           target_s5;
	logic [31:0]           mag_abs [AXES];
	logic                  cap, raise;

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			mag_abs[i] = abs32(vel_s2[i]);
		end
		cap   = (cfg.max_speed != MAX_UNLIMITED) && (vsq_s4 > cfg.max_sq);
		raise = (vsq_s4 != 64'd0) && (vsq_s4 < cfg.min_sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < AXES; i++) begin
				prod_s1[i] <= $signed(in_vel[i]) * $signed({1'b0, cfg.damp[i]});
				vel_s2[i]  <= sat32(64'(prod_s1[i] >>> 14));
				sq_s3[i]   <= mag_abs[i] * mag_abs[i];
			end
			pos_s1 <= in_pos;
			pos_s2 <= pos_s1;
			pos_s3 <= pos_s2;
			vel_s3 <= vel_s2;
			pos_s4 <= pos_s3;
			vel_s4 <= vel_s3;
			vsq_s4 <= sq_s3[0] + sq_s3[1] + sq_s3[2];
			pos_s5 <= pos_s4;
			vel_s5 <= vel_s4;
			vsq_s5 <= vsq_s4;
			if (cap) begin
				act_s5    <= ACT_CAP;
				target_s5 <= cfg.max_speed;
			end else if (raise) begin
				act_s5    <= ACT_RAISE;
				target_s5 <= min_speed;
			end else begin
				act_s5    <= ACT_NONE;
				target_s5 <= 32'd0;
			end
		end
	end

	assign out_valid       = v_s5;
	assign out_side.pos    = pos_s5;
	assign out_side.vel    = vel_s5;
	assign out_side.act    = act_s5;
	assign out_side.target = target_s5;
	assign out_vsq         = vsq_s5;

endmodule

// ===== rtl/pmu_sqrt.sv =====
// ----------------------------------------------------------------------------
// pmu_sqrt
// Integer square root of the squared speed, one root bit per stage.
// ----------------------------------------------------------------------------
module pmu_sqrt import pmu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  side_t       in_side,
	input  logic [63:0] in_vsq,
	output logic        out_valid,
	output side_t       out_side,
	output logic [31:0] out_mag
);

	localparam int STEPS = 32;

	logic        v_s    [STEPS+1];
	side_t       side_s [STEPS+1];
	logic [63:0] x_s    [STEPS+1];
	logic [33:0] rem_s  [STEPS+1];
	logic [31:0] root_s [STEPS+1];

	assign v_s[0]    = in_valid;
	assign side_s[0] = in_side;
	assign x_s[0]    = in_vsq;
	assign rem_s[0]  = 34'd0;
	assign root_s[0] = 32'd0;

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [35:0] acc;
		logic [35:0] trial;
		logic        ge;

		assign acc   = {rem_s[k], x_s[k][63:62]};
		assign trial = {2'b00, root_s[k], 2'b01};
		assign ge    = acc >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= side_s[k];
				x_s[k+1]    <= {x_s[k][61:0], 2'b00};
				rem_s[k+1]  <= ge ? 34'(acc - trial) : acc[33:0];
				root_s[k+1] <= {root_s[k][30:0], ge};
			end
		end
	end

	assign out_valid = v_s[STEPS];
	assign out_side  = side_s[STEPS];
	assign out_mag   = root_s[STEPS];

endmodule

// ===== rtl/pmu_div.sv =====
// ----------------------------------------------------------------------------
// pmu_div
// Rescale of the velocity to the target speed when a cap or raise is set:
// |v|*target/mag per axis, one quotient bit per stage, then sign and saturation.
// ----------------------------------------------------------------------------
module pmu_div import pmu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  side_t       in_side,
	input  logic [31:0] in_mag,
	output logic        out_valid,
	output side_t       out_side
);

	localparam int STEPS = 32;

	logic        v_m;
	side_t       side_m;
	logic [31:0] mag_m;
	logic [63:0] num_m [AXES];

	logic        v_s    [STEPS+1];
	side_t       side_s [STEPS+1];
	logic [31:0] mag_s  [STEPS+1];
	logic [31:0] rem_s  [STEPS+1][AXES];
	logic [31:0] low_s  [STEPS+1][AXES];
	logic [31:0] quo_s  [STEPS+1][AXES];

	logic        v_fin;
	side_t       side_fin;
	side_t       side_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m   <= 1'b0;
			v_fin <= 1'b0;
		end else if (adv) begin
			v_m   <= in_valid;
			v_fin <= v_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_m <= in_side;
			mag_m  <= in_mag;
			for (int i = 0; i < AXES; i++) begin
				num_m[i] <= abs32(in_side.vel[i]) * in_side.target;
			end
		end
	end

	assign v_s[0]    = v_m;
	assign side_s[0] = side_m;
	assign mag_s[0]  = mag_m;
	for (genvar i = 0; i < AXES; i++) begin : g_init
		assign rem_s[0][i] = num_m[i][63:32];
		assign low_s[0][i] = num_m[i][31:0];
		assign quo_s[0][i] = 32'd0;
	end

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (adv) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				side_s[k+1] <= side_s[k];
				mag_s[k+1]  <= mag_s[k];
			end
		end

		for (genvar i = 0; i < AXES; i++) begin : g_lane
			logic [32:0] acc;
			logic        ge;

			assign acc = {rem_s[k][i], low_s[k][i][31]};
			assign ge  = acc >= {1'b0, mag_s[k]};

			always_ff @(posedge clk) begin
				if (adv) begin
					rem_s[k+1][i] <= ge ? 32'(acc - {1'b0, mag_s[k]}) : acc[31:0];
					low_s[k+1][i] <= {low_s[k][i][30:0], 1'b0};
					quo_s[k+1][i] <= {quo_s[k][i][30:0], ge};
				end
			end
		end
	end

	always_comb begin
		side_nx = side_s[STEPS];
		if (side_s[STEPS].act != ACT_NONE) begin
			for (int i = 0; i < AXES; i++) begin
				if (side_s[STEPS].vel[i][31]) begin
					side_nx.vel[i] = (quo_s[STEPS][i] > 32'h8000_0000) ? 32'h8000_0000
						: (~quo_s[STEPS][i] + 32'd1);
				end else begin
					side_nx.vel[i] = (quo_s[STEPS][i] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF
						: quo_s[STEPS][i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_fin <= side_nx;
		end
	end

	assign out_valid = v_fin;
	assign out_side  = side_fin;

endmodule

// ===== rtl/pmu_rear.sv =====
// ----------------------------------------------------------------------------
// pmu_rear
// Euler position step: pos + floor(vel*time_step/2^16), saturated. The last
// stage is the output register.
// ----------------------------------------------------------------------------
module pmu_rear import pmu_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        adv,
	input  logic        in_valid,
	input  side_t       in_side,
	input  logic [19:0] time_step,
	output logic        out_valid,
	output side_t       out_side
);

	logic               v_s1, v_s2;
	side_t              side_s1, side_s2;
	side_t              side_nx;
	logic signed [52:0] prod_s1 [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		side_nx = side_s1;
		for (int i = 0; i < AXES; i++) begin
			side_nx.pos[i] = sat32(64'($signed(side_s1.pos[i])) + 64'(prod_s1[i] >>> 16));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1 <= in_side;
			side_s2 <= side_nx;
			for (int i = 0; i < AXES; i++) begin
				prod_s1[i] <= $signed(in_side.vel[i]) * $signed({1'b0, time_step});
			end
		end
	end

	assign out_valid = v_s2;
	assign out_side  = side_s2;

endmodule
